[src/sla_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sla_pkg
// shared constants, codes and types of the slot allocator
// ----------------------------------------------------------------------------
package sla_pkg;

  localparam int NUM_SLOTS = 32;
  localparam int LIFE_BITS = 8;
  localparam int IDX_W     = $clog2(NUM_SLOTS);

  // transaction field widths
  localparam int CMD_W     = 2;
  localparam int NEWLIFE_W = 8;
  localparam int REL_W     = 5;
  localparam int SLOT_W    = 5;
  localparam int EXP_W     = 6;

  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_WRITE,
    ST_RESP
  } sla_state_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_index;
    logic              stolen;
    logic [EXP_W-1:0]  expired_count;
  } sla_res_t;

endpackage

[src/sla_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sla_if
// valid/ready channels for commands and results of the slot allocator
// ----------------------------------------------------------------------------
interface sla_in_if import sla_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     command;
  logic [NEWLIFE_W-1:0] new_life;
  logic [REL_W-1:0]     release_index;

  modport source (output valid, command, new_life, release_index, input ready);
  modport sink (input valid, command, new_life, release_index, output ready);
endinterface

interface sla_out_if import sla_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] slot_index;
  logic              stolen;
  logic [EXP_W-1:0]  expired_count;

  modport source (output valid, slot_index, stolen, expired_count, input ready);
  modport sink (input valid, slot_index, stolen, expired_count, output ready);
endinterface

[src/sla_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sla_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module sla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/sla_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sla_engine
// command sequencer: valid flags, search pointer and scans over the life ram
// ----------------------------------------------------------------------------
module sla_engine import sla_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  sla_in_if.sink           in_ch,
  output logic             res_valid,
  input  logic             res_take,
  output sla_res_t         res,
  output logic             ram_we,
  output logic [IDX_W-1:0] ram_waddr,
  output logic [LIFE_BITS-1:0] ram_wdata,
  output logic [IDX_W-1:0] ram_raddr,
  input  logic [LIFE_BITS-1:0] ram_rdata
);

  sla_state_t           state_r, state_nxt;
  logic [CMD_W-1:0]     cmd_r, cmd_nxt;
  logic [LIFE_BITS-1:0] life_r, life_nxt;
  logic [IDX_W-1:0]     start_r, start_nxt;
  logic [IDX_W-1:0]     cnt_r, cnt_nxt;
  logic                 rd_pend_r, rd_pend_nxt;
  logic [IDX_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic                 have_best_r, have_best_nxt;
  logic [IDX_W-1:0]     best_r, best_nxt;
  logic [LIFE_BITS-1:0] best_life_r, best_life_nxt;
  logic [IDX_W-1:0]     chosen_r, chosen_nxt;
  logic                 stolen_r, stolen_nxt;
  logic [EXP_W-1:0]     exp_r, exp_nxt;
  logic [NUM_SLOTS-1:0] valid_r, valid_nxt;

  logic                 accept;
  logic                 is_alloc;
  logic [IDX_W:0]       scan_sum;
  logic [IDX_W-1:0]     scan_idx;
  logic                 free_hit;
  logic                 best_upd;
  logic [LIFE_BITS-1:0] life_masked;
  logic [LIFE_BITS-1:0] life_dec;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_alloc    = (cmd_r == CMD_ALLOC);

  // allocate walks from the pointer with wrap, tick walks from slot zero
  always_comb begin
    scan_sum = {1'b0, (is_alloc ? start_r : '0)} + {1'b0, cnt_r};
    if (scan_sum >= (IDX_W+1)'(NUM_SLOTS)) begin
      scan_sum = scan_sum - (IDX_W+1)'(NUM_SLOTS);
    end
    scan_idx = scan_sum[IDX_W-1:0];
  end

  assign free_hit    = is_alloc && !valid_r[scan_idx];
  assign best_upd    = rd_pend_r && (!have_best_r || ram_rdata < best_life_r);
  assign life_masked = in_ch.new_life[LIFE_BITS-1:0];
  assign life_dec    = ram_rdata - LIFE_BITS'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_ch.command == CMD_ALLOC || in_ch.command == CMD_TICK) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end
      ST_SCAN: begin
        if (free_hit) begin
          state_nxt = ST_WRITE;
        end else if (cnt_r == IDX_W'(NUM_SLOTS - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = is_alloc ? ST_WRITE : ST_RESP;
      ST_WRITE: state_nxt = ST_RESP;
      ST_RESP: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_nxt       = cmd_r;
    life_nxt      = life_r;
    start_nxt     = start_r;
    cnt_nxt       = cnt_r;
    rd_pend_nxt   = rd_pend_r;
    rd_idx_nxt    = rd_idx_r;
    have_best_nxt = have_best_r;
    best_nxt      = best_r;
    best_life_nxt = best_life_r;
    chosen_nxt    = chosen_r;
    stolen_nxt    = stolen_r;
    exp_nxt       = exp_r;
    valid_nxt     = valid_r;
    ram_we        = 1'b0;
    ram_waddr     = rd_idx_r;
    ram_wdata     = life_dec;
    ram_raddr     = scan_idx;
    res_valid     = 1'b0;
    res.slot_index    = SLOT_W'(chosen_r);
    res.stolen        = stolen_r;
    res.expired_count = exp_r;

    // consume the entry read in the previous cycle
    if (state_r == ST_SCAN || state_r == ST_DRAIN) begin
      if (is_alloc) begin
        if (best_upd) begin
          have_best_nxt = 1'b1;
          best_nxt      = rd_idx_r;
          best_life_nxt = ram_rdata;
        end
      end else if (rd_pend_r && valid_r[rd_idx_r]) begin
        ram_we = 1'b1;
        if (life_dec == '0) begin
          valid_nxt[rd_idx_r] = 1'b0;
          exp_nxt             = exp_r + EXP_W'(1);
        end
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt       = in_ch.command;
          life_nxt      = (life_masked == '0) ? LIFE_BITS'(1) : life_masked;
          cnt_nxt       = '0;
          rd_pend_nxt   = 1'b0;
          have_best_nxt = 1'b0;
          chosen_nxt    = '0;
          stolen_nxt    = 1'b0;
          exp_nxt       = '0;
          if (in_ch.command == CMD_RELEASE &&
              32'(in_ch.release_index) < NUM_SLOTS) begin
            valid_nxt[in_ch.release_index[IDX_W-1:0]] = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        if (free_hit) begin
          chosen_nxt  = scan_idx;
          rd_pend_nxt = 1'b0;
        end else begin
          rd_pend_nxt = 1'b1;
          rd_idx_nxt  = scan_idx;
          cnt_nxt     = cnt_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        rd_pend_nxt = 1'b0;
        if (is_alloc) begin
          // every slot live: evict the first shortest life in scan order
          chosen_nxt = best_upd ? rd_idx_r : best_r;
          stolen_nxt = 1'b1;
        end
      end
      ST_WRITE: begin
        ram_we              = 1'b1;
        ram_waddr           = chosen_r;
        ram_wdata           = life_r;
        valid_nxt[chosen_r] = 1'b1;
        start_nxt = (chosen_r == IDX_W'(NUM_SLOTS - 1)) ? '0 : chosen_r + IDX_W'(1);
      end
      ST_RESP: res_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      start_r   <= '0;
      valid_r   <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      start_r   <= start_nxt;
      valid_r   <= valid_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    life_r      <= life_nxt;
    cnt_r       <= cnt_nxt;
    rd_idx_r    <= rd_idx_nxt;
    have_best_r <= have_best_nxt;
    best_r      <= best_nxt;
    best_life_r <= best_life_nxt;
    chosen_r    <= chosen_nxt;
    stolen_r    <= stolen_nxt;
    exp_r       <= exp_nxt;
  end

endmodule

[src/slot_allocator_steal_shortest_life_top.sv]
`timescale 1ns / 1ps
// flow: release and unknown commands go straight to the result; tick scans every
//   slot from slot zero; allocate scans from the pointer and stops at the first free
//   slot, or scans every slot and steals when all are live; the output register follows
// throughput: one transaction at a time, paced by the scan over the single
//   read port of the life ram
// reset: synchronous active low; valid flags and pointer clear at once, no clearing pass
// ----------------------------------------------------------------------------
// slot_allocator_steal_shortest_life_top
// round-robin slot allocator with shortest-lifetime eviction
// ----------------------------------------------------------------------------
module slot_allocator_steal_shortest_life_top import sla_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  sla_in_if.sink    in_ch,
  sla_out_if.source out_ch
);

  logic                 res_valid;
  logic                 res_take;
  sla_res_t             res;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [LIFE_BITS-1:0] ram_wdata;
  logic [IDX_W-1:0]     ram_raddr;
  logic [LIFE_BITS-1:0] ram_rdata;

  logic                 out_valid_r, out_valid_nxt;
  sla_res_t             out_res_r, out_res_nxt;

  sla_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  sla_ram #(
    .WIDTH (LIFE_BITS),
    .DEPTH (NUM_SLOTS)
  ) u_life_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output register lets the engine take the next command while a result waits
  assign res_take = res_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.slot_index    = out_res_r.slot_index;
  assign out_ch.stolen        = out_res_r.stolen;
  assign out_ch.expired_count = out_res_r.expired_count;

endmodule

[src/sla_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sla_checker
// port-level checks of the slot allocator, bound to the top level
// ----------------------------------------------------------------------------
module sla_checker import sla_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [SLOT_W-1:0] out_slot_index,
  input logic              out_stolen,
  input logic [EXP_W-1:0]  out_expired_count
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_r, pend_nxt;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // transactions taken in but not yet delivered
  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) begin
      pend_nxt = pend_r + 2'd1;
    end else if (!in_acc && out_acc) begin
      pend_nxt = pend_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> (pend_r != 2'd0))
    else $error("result delivered with no transaction outstanding");

  a_at_most_two_pending: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("more than two transactions outstanding");

  a_steal_has_no_expiry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stolen) |-> (out_expired_count == '0))
    else $error("allocate result carries an expired count");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_slot_index) && $stable(out_stolen)
       && $stable(out_expired_count)))
    else $error("stalled result changed");

endmodule

bind slot_allocator_steal_shortest_life_top sla_checker u_sla_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_slot_index    (out_ch.slot_index),
  .out_stolen        (out_ch.stolen),
  .out_expired_count (out_ch.expired_count)
);
